// ===== design/byte_array_sort_and_search_macros.svh =====
// Assertion helpers shared by the block's modules.
// They sample on clk and are switched off while rst_n is low.
`ifndef BYTE_ARRAY_SORT_AND_SEARCH_MACROS_SVH
`define BYTE_ARRAY_SORT_AND_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BASS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BASS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bass_pkg.sv =====
`timescale 1ns / 1ps

package bass_pkg;

    localparam int ENTRIES_DEFAULT = 32;
    localparam int MAX_RESULTS     = 32;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 5;
    localparam int DATA_W  = 8;
    localparam int POS_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_SORT   = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_SEARCH  = 1'b1;

    typedef struct packed {
        logic store_write;
        logic sort_start;
        logic sort_load;
        logic sort_step;
        logic sort_flush;
        logic emit_step;
        logic search_start;
        logic search_step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic idx_last;
        logic emit_last;
        logic swapped;
        logic search_done;
    } dp_stat_t;

endpackage

// ===== design/bass_ifs.sv =====
`timescale 1ns / 1ps

interface bass_in_if;
    logic                                valid;
    logic                                ready;
    logic [bass_pkg::OP_W-1:0]           op;
    logic [bass_pkg::SLOT_W-1:0]         slot;
    logic signed [bass_pkg::DATA_W-1:0]  element_value;
    logic signed [bass_pkg::DATA_W-1:0]  search_key;

    modport source (output valid, op, slot, element_value, search_key, input ready);
    modport sink (input valid, op, slot, element_value, search_key, output ready);
endinterface

interface bass_out_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [bass_pkg::DATA_W-1:0]  data_value;
    logic [bass_pkg::POS_W-1:0]          position;
    logic                                found;
    logic                                last;

    modport source (output valid, kind, data_value, position, found, last, input ready);
    modport sink (input valid, kind, data_value, position, found, last, output ready);
endinterface

// ===== design/bass_ram.sv =====
`timescale 1ns / 1ps

module bass_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bass_ctrl.sv =====
`timescale 1ns / 1ps
`include "byte_array_sort_and_search_macros.svh"

module bass_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [bass_pkg::OP_W-1:0]  in_op,
    output logic                       in_ready,
    input  bass_pkg::dp_stat_t         stat,
    output bass_pkg::dp_cmd_t          cmd
);

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_SORT_LOAD  = 6'b000010,
        ST_SORT_STEP  = 6'b000100,
        ST_SORT_FLUSH = 6'b001000,
        ST_EMIT       = 6'b010000,
        ST_SEARCH     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        bass_pkg::OP_WRITE:
                        begin
                            cmd.store_write = 1'b1;
                        end
                        bass_pkg::OP_SORT:
                        begin
                            cmd.sort_start = 1'b1;
                            state_next     = ST_SORT_LOAD;
                        end
                        bass_pkg::OP_SEARCH:
                        begin
                            cmd.search_start = 1'b1;
                            state_next       = ST_SEARCH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SORT_LOAD:
            begin
                cmd.sort_load = 1'b1;
                state_next    = ST_SORT_STEP;
            end
            ST_SORT_STEP:
            begin
                cmd.sort_step = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_SORT_FLUSH;
                end
            end
            ST_SORT_FLUSH:
            begin
                cmd.sort_flush = 1'b1;
                state_next     = stat.swapped ? ST_SORT_LOAD : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (stat.out_free)
                begin
                    cmd.search_step = 1'b1;
                    if (stat.search_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `BASS_ASSERT_SAME(a_result_slot_free, (cmd.emit_step || cmd.search_step), stat.out_free,
        "A result was produced while the output register was still occupied.")

endmodule

// ===== design/bass_dp.sv =====
`timescale 1ns / 1ps
`include "byte_array_sort_and_search_macros.svh"

module bass_dp #(
    parameter int ENTRIES = bass_pkg::ENTRIES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bass_pkg::dp_cmd_t                   cmd,
    output bass_pkg::dp_stat_t                  stat,
    input  logic [bass_pkg::SLOT_W-1:0]         slot,
    input  logic signed [bass_pkg::DATA_W-1:0]  element_value,
    input  logic signed [bass_pkg::DATA_W-1:0]  search_key,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_kind,
    output logic signed [bass_pkg::DATA_W-1:0]  out_data_value,
    output logic [bass_pkg::POS_W-1:0]          out_position,
    output logic                                out_found,
    output logic                                out_last
);

    localparam int AW     = $clog2(ENTRIES);
    localparam int BW     = AW + 1;
    localparam int EMIT_N = (ENTRIES < bass_pkg::MAX_RESULTS) ? ENTRIES : bass_pkg::MAX_RESULTS;
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
    localparam logic [AW-1:0] EMIT_END = AW'(EMIT_N - 1);
    localparam logic [AW-1:0] MID0     = AW'((ENTRIES - 1) / 2);

    logic [AW-1:0]                     idx_reg, idx_next;
    logic                              swapped_reg, swapped_next;
    logic signed [bass_pkg::DATA_W-1:0] carry_reg, carry_next;
    logic signed [bass_pkg::DATA_W-1:0] key_reg, key_next;
    logic [BW-1:0]                     lo_reg, lo_next;
    logic [BW-1:0]                     hb_reg, hb_next;
    logic [AW-1:0]                     mid_reg, mid_next;

    logic                              ov_reg, ov_next;
    logic                              kind_reg, kind_next;
    logic signed [bass_pkg::DATA_W-1:0] data_reg, data_next;
    logic [bass_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic                              found_reg, found_next;
    logic                              last_reg, last_next;
    logic                              out_load;

    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic [bass_pkg::DATA_W-1:0]       wr_data;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic [bass_pkg::DATA_W-1:0]       rd_data;
    logic signed [bass_pkg::DATA_W-1:0] rd_val;

    logic                              idx_last;
    logic                              emit_last;
    logic                              carry_gt;
    logic                              key_eq;
    logic                              key_gt;
    logic [BW-1:0]                     lo_cand;
    logic [BW-1:0]                     hb_cand;
    logic [BW:0]                       mid_sum;
    logic                              range_empty;
    logic                              search_done;

    bass_ram #(
        .WIDTH (bass_pkg::DATA_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_val    = signed'(rd_data);
    assign idx_last  = (idx_reg == LAST_IDX);
    assign emit_last = (idx_reg == EMIT_END);
    assign carry_gt  = (carry_reg > rd_val);

    assign key_eq      = (rd_val == key_reg);
    assign key_gt      = (rd_val < key_reg);
    assign lo_cand     = key_gt ? (BW'(mid_reg) + BW'(1)) : lo_reg;
    assign hb_cand     = key_gt ? hb_reg : BW'(mid_reg);
    assign mid_sum     = {1'b0, lo_cand} + {1'b0, hb_cand} - (BW + 1)'(1);
    assign range_empty = !(lo_cand < hb_cand);
    assign search_done = key_eq || range_empty;

    assign stat.out_free    = !ov_reg || out_ready;
    assign stat.idx_last    = idx_last;
    assign stat.emit_last   = emit_last;
    assign stat.swapped     = swapped_reg;
    assign stat.search_done = search_done;

    always_comb
    begin
        idx_next     = idx_reg;
        swapped_next = swapped_reg;
        carry_next   = carry_reg;
        key_next     = key_reg;
        lo_next      = lo_reg;
        hb_next      = hb_reg;
        mid_next     = mid_reg;
        out_load     = 1'b0;
        kind_next    = kind_reg;
        data_next    = data_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        last_next    = last_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg - AW'(1);
        wr_data      = carry_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;

        if (cmd.store_write)
        begin
            wr_en   = (32'(slot) < ENTRIES);
            wr_addr = AW'(slot);
            wr_data = element_value;
        end

        if (cmd.sort_start)
        begin
            rd_en        = 1'b1;
            rd_addr      = '0;
            idx_next     = AW'(1);
            swapped_next = 1'b0;
        end

        if (cmd.sort_load)
        begin
            rd_en      = 1'b1;
            rd_addr    = idx_reg;
            carry_next = rd_val;
        end

        if (cmd.sort_step)
        begin
            wr_en        = 1'b1;
            wr_addr      = idx_reg - AW'(1);
            wr_data      = carry_gt ? rd_val : carry_reg;
            carry_next   = carry_gt ? carry_reg : rd_val;
            swapped_next = swapped_reg || carry_gt;
            rd_en        = !idx_last;
            rd_addr      = idx_reg + AW'(1);
            idx_next     = idx_reg + AW'(1);
        end

        if (cmd.sort_flush)
        begin
            wr_en        = 1'b1;
            wr_addr      = LAST_IDX;
            wr_data      = carry_reg;
            rd_en        = 1'b1;
            rd_addr      = '0;
            idx_next     = swapped_reg ? AW'(1) : '0;
            swapped_next = 1'b0;
        end

        if (cmd.emit_step)
        begin
            out_load   = 1'b1;
            kind_next  = bass_pkg::KIND_ELEMENT;
            data_next  = rd_val;
            pos_next   = bass_pkg::POS_W'(idx_reg);
            found_next = 1'b0;
            last_next  = emit_last;
            rd_en      = !emit_last;
            rd_addr    = idx_reg + AW'(1);
            idx_next   = emit_last ? '0 : idx_reg + AW'(1);
        end

        if (cmd.search_start)
        begin
            key_next = search_key;
            lo_next  = '0;
            hb_next  = BW'(ENTRIES);
            mid_next = MID0;
            rd_en    = 1'b1;
            rd_addr  = MID0;
        end

        if (cmd.search_step)
        begin
            if (search_done)
            begin
                out_load   = 1'b1;
                kind_next  = bass_pkg::KIND_SEARCH;
                data_next  = '0;
                pos_next   = key_eq ? bass_pkg::POS_W'(mid_reg) : '0;
                found_next = key_eq;
                last_next  = 1'b1;
            end
            else
            begin
                lo_next  = lo_cand;
                hb_next  = hb_cand;
                mid_next = mid_sum[AW:1];
                rd_en    = 1'b1;
                rd_addr  = mid_sum[AW:1];
            end
        end

        if (out_load)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg      <= 1'b0;
            idx_reg     <= '0;
            swapped_reg <= 1'b0;
            lo_reg      <= '0;
            hb_reg      <= '0;
            mid_reg     <= '0;
        end
        else
        begin
            ov_reg      <= ov_next;
            idx_reg     <= idx_next;
            swapped_reg <= swapped_next;
            lo_reg      <= lo_next;
            hb_reg      <= hb_next;
            mid_reg     <= mid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        key_reg   <= key_next;
        kind_reg  <= kind_next;
        data_reg  <= data_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        last_reg  <= last_next;
    end

    assign out_valid      = ov_reg;
    assign out_kind       = kind_reg;
    assign out_data_value = data_reg;
    assign out_position   = pos_reg;
    assign out_found      = found_reg;
    assign out_last       = last_reg;

    `BASS_ASSERT_SAME(a_no_port_collision, (wr_en && rd_en), (wr_addr != rd_addr),
        "The store was read and written at the same address in one cycle.")
    `BASS_ASSERT_SAME(a_probe_in_range, cmd.search_step,
        ((BW'(mid_reg) >= lo_reg) && (BW'(mid_reg) < hb_reg)),
        "A search probe fell outside the live range.")
    `BASS_ASSERT_NEXT(a_search_answer_shown, (cmd.search_step && search_done),
        (ov_reg && last_reg && (kind_reg == bass_pkg::KIND_SEARCH)),
        "A finished search did not present its answer.")

endmodule

// ===== design/byte_array_sort_and_search.sv =====
`timescale 1ns / 1ps
// Holds ENTRIES signed bytes in a single-port-read, single-port-write memory.
// A write beat stores one byte and gives no result; slots at or beyond
// ENTRIES and op 3 are ignored. A sort beat bubble-sorts the array in place:
// each pass streams the memory once with the larger byte carried in a
// register, and sorting stops after the first pass without an exchange;
// then the elements stream out at one beat per cycle while the output
// register is free, smallest first, at most 32 of them, the final one
// marked last. A search beat probes the array as stored with a binary
// search, one probe per cycle after a registered memory read while the
// output register is free. Results wait in an output register; a new beat
// is taken once the previous one has produced all of its results. Entries
// hold no defined value until written, and sorting or searching an array
// with unwritten entries gives undefined results.
module byte_array_sort_and_search #(
    parameter int ENTRIES = bass_pkg::ENTRIES_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    bass_in_if.sink   item,
    bass_out_if.source result
);

    bass_pkg::dp_cmd_t  cmd;
    bass_pkg::dp_stat_t stat;

    bass_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_op    (item.op),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bass_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .slot           (item.slot),
        .element_value  (item.element_value),
        .search_key     (item.search_key),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_kind       (result.kind),
        .out_data_value (result.data_value),
        .out_position   (result.position),
        .out_found      (result.found),
        .out_last       (result.last)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

typedef struct packed {
    logic                               kind;
    logic signed [bass_pkg::DATA_W-1:0] data_value;
    logic [bass_pkg::POS_W-1:0]         position;
    logic                               found;
    logic                               last;
} bass_result_t;

class bass_scoreboard;
    localparam int SLOTS = bass_pkg::ENTRIES_DEFAULT;
    localparam int EMIT_COUNT = (SLOTS < bass_pkg::MAX_RESULTS) ? SLOTS : bass_pkg::MAX_RESULTS;

    logic signed [bass_pkg::DATA_W-1:0] array_copy [SLOTS];
    bass_result_t                       awaited_q [$];
    int                                 errors;

    function new();
        errors = 0;
        foreach (array_copy[i])
        begin
            array_copy[i] = '0;
        end
    endfunction

    function int pending();
        return awaited_q.size();
    endfunction

    function logic signed [bass_pkg::DATA_W-1:0] pick_stored();
        return array_copy[$urandom_range(SLOTS - 1)];
    endfunction

    function void sort_array();
        logic signed [bass_pkg::DATA_W-1:0] cur;
        int j;
        for (int i = 1; i < SLOTS; i++)
        begin
            cur = array_copy[i];
            j = i - 1;
            while (j >= 0 && array_copy[j] > cur)
            begin
                array_copy[j + 1] = array_copy[j];
                j--;
            end
            array_copy[j + 1] = cur;
        end
    endfunction

    function void note_beat(logic [bass_pkg::OP_W-1:0] op, logic [bass_pkg::SLOT_W-1:0] slot,
                            logic signed [bass_pkg::DATA_W-1:0] value,
                            logic signed [bass_pkg::DATA_W-1:0] key);
        bass_result_t res;
        int lo;
        int hi;
        int mid;
        bit hit;
        case (op)
            bass_pkg::OP_WRITE:
            begin
                if (slot < SLOTS)
                begin
                    array_copy[slot] = value;
                end
            end
            bass_pkg::OP_SORT:
            begin
                sort_array();
                for (int i = 0; i < EMIT_COUNT; i++)
                begin
                    res.kind = bass_pkg::KIND_ELEMENT;
                    res.data_value = array_copy[i];
                    res.position = i[bass_pkg::POS_W-1:0];
                    res.found = 1'b0;
                    res.last = (i == EMIT_COUNT - 1);
                    awaited_q.push_back(res);
                end
            end
            bass_pkg::OP_SEARCH:
            begin
                lo = 0;
                hi = SLOTS - 1;
                mid = 0;
                hit = 1'b0;
                while (lo <= hi && !hit)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (array_copy[mid] == key)
                    begin
                        hit = 1'b1;
                    end
                    else if (array_copy[mid] < key)
                    begin
                        lo = mid + 1;
                    end
                    else
                    begin
                        hi = mid - 1;
                    end
                end
                res.kind = bass_pkg::KIND_SEARCH;
                res.data_value = '0;
                res.position = hit ? mid[bass_pkg::POS_W-1:0] : '0;
                res.found = hit;
                res.last = 1'b1;
                awaited_q.push_back(res);
            end
            default:
            begin
            end
        endcase
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task check_result(bass_result_t got);
        bass_result_t want;
        if (awaited_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result beat %p", got));
            return;
        end
        want = awaited_q.pop_front();
        if (got.kind !== want.kind)
        begin
            report_mismatch($sformatf("kind %0b, expected %0b", got.kind, want.kind));
        end
        if (got.data_value !== want.data_value)
        begin
            report_mismatch($sformatf("data_value %0d, expected %0d",
                                      got.data_value, want.data_value));
        end
        if (got.position !== want.position)
        begin
            report_mismatch($sformatf("position %0d, expected %0d",
                                      got.position, want.position));
        end
        if (got.found !== want.found)
        begin
            report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
        end
        if (got.last !== want.last)
        begin
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
        end
    endtask
endclass

module tb_top;

    localparam logic [bass_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 406;
    localparam int HOLD_CYCLES   = 2000;
    localparam int SETTLE_CYCLES = 1200;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;

    bass_in_if  item_bus ();
    bass_out_if result_bus ();

    bass_scoreboard board;
    int             src_idle_pct;
    int             sink_idle_pct;
    bit             hold_req;
    bit             hold_taken;
    longint         cycles = 0;

    byte_array_sort_and_search uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** byte_array_sort_and_search: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            board.check_result('{result_bus.kind, result_bus.data_value,
                                 result_bus.position, result_bus.found, result_bus.last});
        end
    end

    // The receiver; a requested hold-off keeps ready low so that the block backs up.
    initial
    begin
        result_bus.ready = 1'b0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_beat(input logic [bass_pkg::OP_W-1:0] op,
                             input logic [bass_pkg::SLOT_W-1:0] slot,
                             input logic signed [bass_pkg::DATA_W-1:0] value,
                             input logic signed [bass_pkg::DATA_W-1:0] key);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.op <= op;
        item_bus.slot <= slot;
        item_bus.element_value <= value;
        item_bus.search_key <= key;
        @(posedge clk);
        while (item_bus.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        board.note_beat(op, slot, value, key);
        @(negedge clk);
    endtask

    function automatic logic signed [bass_pkg::DATA_W-1:0] edge_byte();
        case ($urandom_range(3))
            0: return 8'sh80;
            1: return 8'sh7f;
            2: return 8'sh00;
            default: return 8'shff;
        endcase
    endfunction

    task automatic random_beat(output bit counted);
        int pick;
        logic signed [bass_pkg::DATA_W-1:0] value;
        pick = $urandom_range(99);
        counted = 1'b1;
        if (pick < 50)
        begin
            value = ($urandom_range(99) < 25) ? edge_byte()
                                              : bass_pkg::DATA_W'($urandom_range(255));
            send_beat(bass_pkg::OP_WRITE, bass_pkg::SLOT_W'($urandom_range(31)), value,
                      bass_pkg::DATA_W'($urandom_range(255)));
        end
        else if (pick < 62)
        begin
            send_beat(bass_pkg::OP_SORT, bass_pkg::SLOT_W'($urandom_range(31)),
                      bass_pkg::DATA_W'($urandom_range(255)),
                      bass_pkg::DATA_W'($urandom_range(255)));
        end
        else if (pick < 96)
        begin
            value = ($urandom_range(99) < 65) ? board.pick_stored()
                                              : bass_pkg::DATA_W'($urandom_range(255));
            send_beat(bass_pkg::OP_SEARCH, bass_pkg::SLOT_W'($urandom_range(31)),
                      bass_pkg::DATA_W'($urandom_range(255)), value);
        end
        else
        begin
            send_beat(OP_UNUSED, bass_pkg::SLOT_W'($urandom_range(31)),
                      bass_pkg::DATA_W'($urandom_range(255)),
                      bass_pkg::DATA_W'($urandom_range(255)));
            counted = 1'b0;
        end
    endtask

    initial
    begin
        int  done_items;
        bit  counted;
        int  phase;
        board = new();
        src_idle_pct = 29;
        sink_idle_pct = 76;
        hold_req = 1'b0;
        rst_n = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.op = bass_pkg::OP_WRITE;
        item_bus.slot = '0;
        item_bus.element_value = '0;
        item_bus.search_key = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every slot is written first, in descending order, so nothing undefined is read.
        for (int i = 0; i < 32; i++)
        begin
            send_beat(bass_pkg::OP_WRITE, i[bass_pkg::SLOT_W-1:0],
                      (i == 31) ? 8'sh80 : bass_pkg::DATA_W'(127 - 8 * i), 8'sh00);
        end

        send_beat(OP_UNUSED, 5'd3, 8'sh55, 8'sh55);
        send_beat(bass_pkg::OP_SEARCH, 5'd0, 8'sh00, 8'sh7f);
        send_beat(bass_pkg::OP_SEARCH, 5'd0, 8'sh00, 8'sd7);
        hold_req = 1'b1;
        send_beat(bass_pkg::OP_SORT, 5'd0, 8'sh00, 8'sh00);
        send_beat(bass_pkg::OP_SORT, 5'd31, 8'sh7f, 8'sh80);
        send_beat(bass_pkg::OP_SEARCH, 5'd0, 8'sh00, 8'sh80);
        send_beat(bass_pkg::OP_SEARCH, 5'd0, 8'sh00, 8'sh7f);
        send_beat(bass_pkg::OP_SEARCH, 5'd0, 8'sh00, 8'sh00);
        send_beat(bass_pkg::OP_SEARCH, 5'd0, 8'sh00, 8'shff);
        send_beat(bass_pkg::OP_WRITE, 5'd0, 8'sh7f, 8'sh00);
        send_beat(bass_pkg::OP_WRITE, 5'd31, 8'sh80, 8'sh00);
        send_beat(bass_pkg::OP_SORT, 5'd0, 8'sh00, 8'sh00);
        send_beat(bass_pkg::OP_SEARCH, 5'd0, 8'sh00, 8'sh7f);
        send_beat(bass_pkg::OP_WRITE, 5'd5, 8'sh00, 8'sh00);
        send_beat(bass_pkg::OP_SEARCH, 5'd0, 8'sh00, 8'sh00);

        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            phase = (done_items * 3) / RANDOM_ITEMS;
            src_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 76 : 0;
            sink_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 29 : 0;
            random_beat(counted);
            if (counted)
            begin
                done_items++;
            end
        end
        item_bus.valid <= 1'b0;

        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("** byte_array_sort_and_search: PASSED **");
        end
        else
        begin
            $display("** byte_array_sort_and_search: FAILED **");
        end
        $finish;
    end
endmodule

// ===== byte_array_sort_and_search.f =====
+incdir+design
design/bass_pkg.sv
design/bass_ifs.sv
design/bass_ram.sv
design/bass_ctrl.sv
design/bass_dp.sv
design/byte_array_sort_and_search.sv
tb/tb_top.sv
